// ----- src/qws_pkg.sv -----
// Shared constants, request codes and controller/datapath interface types.
`timescale 1ns / 1ps

package qws_pkg;

  // Counter and field widths.
  localparam int COUNT_WIDTH = 32;
  localparam int FRAC_BITS   = 8;
  localparam int REQ_W       = 2;
  localparam int CPR_W       = 16;
  localparam int MS_W        = 16;
  localparam int OUT_W       = 32;

  // Request codes carried in req_type.
  localparam logic [REQ_W-1:0] REQ_EDGE_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EDGE_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SPEED  = 2'd2;

  localparam logic [CPR_W-1:0] CPR_RESET = 16'd4096;
  localparam int MS_PER_SEC  = 1000;
  localparam int SEC_PER_MIN = 60;
  localparam int AVG_SHIFT   = 2;

  // RPM scale factor: milliseconds per minute, in fixed point.
  localparam int RPM_SCALE_VAL = (MS_PER_SEC * SEC_PER_MIN) << FRAC_BITS;
  localparam int K_W           = $clog2(RPM_SCALE_VAL + 1);
  localparam logic [K_W-1:0] RPM_SCALE = K_W'(RPM_SCALE_VAL);

  // Divider widths: numerator is magnitude times scale, denominator cpr times ms.
  localparam int NUM_W     = COUNT_WIDTH + K_W;
  localparam int DEN_W     = CPR_W + MS_W;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam logic [NUM_W-1:0] RPM_POS_MAX =
    {{(NUM_W-OUT_W){1'b0}}, 1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [NUM_W-1:0] RPM_NEG_MAX =
    {{(NUM_W-OUT_W){1'b0}}, 1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic edge_a;    // step channel A counter
    logic edge_b;    // step channel B counter
    logic snap;      // take count deltas and latch the request
    logic mul;       // form numerator and denominator
    logic div_step;  // one quotient bit
    logic finish;    // load the result register
  } cmd_t;

  typedef struct packed {
    logic bad;       // latched request had a zero interval
  } status_t;

endpackage

// ----- src/qws_ctrl.sv -----
// Controller state machine: request sequencing, divide counter and output valid.
`timescale 1ns / 1ps

module qws_ctrl
  import qws_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [REQ_W-1:0] req_type,
  output logic             out_valid,
  input  logic             out_stall,
  input  status_t          status,
  output cmd_t             cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic                 out_valid_next;
  logic                 accept;
  logic                 out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    div_cnt_next   = div_cnt;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_EDGE_A: cmd.edge_a = 1'b1;
            REQ_EDGE_B: cmd.edge_b = 1'b1;
            REQ_SPEED: begin
              cmd.snap   = 1'b1;
              state_next = S_MUL;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul      = 1'b1;
        div_cnt_next = DIV_CNT_W'(NUM_W - 1);
        state_next   = status.bad ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt - 1'b1;
        if (div_cnt == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the finished request until the result register is free.
        if (out_free) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- src/qws_dp.sv -----
// Datapath: channel counters, count deltas, multipliers, serial divider, result register.
`timescale 1ns / 1ps

module qws_dp
  import qws_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  input  logic                    level_a,
  input  logic                    level_b,
  input  logic [MS_W-1:0]         interval_ms,
  input  logic                    cfg_write,
  input  logic [CPR_W-1:0]        cfg_data,
  output status_t                 status,
  output logic signed [OUT_W-1:0] rpm_q8,
  output logic signed [OUT_W-1:0] count_change,
  output logic                    clipped,
  output logic                    bad_interval
);

  logic [COUNT_WIDTH-1:0]        count_a, count_b, prev_a, prev_b;
  logic [CPR_W-1:0]              cpr;
  logic [MS_W-1:0]               ms_reg;
  logic                          bad_reg, neg_reg;
  logic signed [COUNT_WIDTH-1:0] delta_reg;
  logic [COUNT_WIDTH-1:0]        mag_reg;
  logic [NUM_W-1:0]              quo;
  logic [DEN_W-1:0]              den, rem;

  logic [COUNT_WIDTH-1:0]        da, db;
  logic [COUNT_WIDTH:0]          sum;
  logic signed [COUNT_WIDTH-1:0] delta;
  logic [COUNT_WIDTH-1:0]        mag;
  logic [CPR_W-1:0]              cpr_eff;
  logic [DEN_W:0]                shifted;
  logic [DEN_W+1:0]              diff;
  logic                          ge;
  logic                          clip;
  logic [OUT_W-1:0]              q_low;

  assign status.bad = bad_reg;

  // A quarter of the sum of the two deltas, rounded toward minus infinity.
  assign da    = count_a - prev_a;
  assign db    = count_b - prev_b;
  assign sum   = {da[COUNT_WIDTH-1], da} + {db[COUNT_WIDTH-1], db};
  assign delta = {{(AVG_SHIFT-1){sum[COUNT_WIDTH]}}, sum[COUNT_WIDTH:AVG_SHIFT]};
  assign mag   = delta[COUNT_WIDTH-1] ? (~delta + 1'b1) : delta;

  assign cpr_eff = (cpr == '0) ? CPR_W'(1) : cpr;

  // Restoring divide step; the numerator register fills with quotient bits.
  assign shifted = {rem, quo[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den};
  assign ge      = !diff[DEN_W+1];

  assign clip  = neg_reg ? (quo > RPM_NEG_MAX) : (quo > RPM_POS_MAX);
  assign q_low = quo[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0;
      count_b <= '0;
      prev_a  <= '0;
      prev_b  <= '0;
      cpr     <= CPR_RESET;
    end else begin
      if (cfg_write) begin
        cpr <= cfg_data;
      end
      if (cmd.edge_a) begin
        count_a <= (level_a == level_b) ? count_a - 1'b1 : count_a + 1'b1;
      end
      if (cmd.edge_b) begin
        count_b <= (level_a != level_b) ? count_b - 1'b1 : count_b + 1'b1;
      end
      if (cmd.snap) begin
        prev_a <= count_a;
        prev_b <= count_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      delta_reg <= delta;
      mag_reg   <= mag;
      neg_reg   <= delta[COUNT_WIDTH-1];
      ms_reg    <= interval_ms;
      bad_reg   <= (interval_ms == '0);
    end
    if (cmd.mul) begin
      quo <= {{K_W{1'b0}}, mag_reg} * {{COUNT_WIDTH{1'b0}}, RPM_SCALE};
      den <= {{MS_W{1'b0}}, cpr_eff} * {{CPR_W{1'b0}}, ms_reg};
      rem <= '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
    if (cmd.finish) begin
      count_change <= OUT_W'(delta_reg);
      bad_interval <= bad_reg;
      clipped      <= !bad_reg && clip;
      if (bad_reg) begin
        rpm_q8 <= '0;
      end else if (clip) begin
        rpm_q8 <= neg_reg ? RPM_NEG_MAX[OUT_W-1:0] : RPM_POS_MAX[OUT_W-1:0];
      end else begin
        rpm_q8 <= neg_reg ? (~q_low + 1'b1) : q_low;
      end
    end
  end

endmodule

// ----- src/quadrature_wheel_speed.sv -----
// Top level: quadrature decoder and speed meter for one wheel.
`timescale 1ns / 1ps

// Edge requests (req_type A or B) step that channel's wrapping counter. A speed
// request takes a quarter of the sum of the two channels' count changes since
// the previous speed request and reports RPM in signed fixed point with
// FRAC_BITS fraction bits, truncated toward zero and saturated to 32 bits. A
// speed request first takes the deltas, then forms numerator and denominator in
// the two multipliers, runs the bit-serial restoring divider for NUM_W quotient
// bits, and finally loads the result register. A zero interval skips the
// divider. A result waiting to be taken does not block edge requests or the
// start of the next speed request. counts_per_rev may be written whenever no
// request is in flight.
module quadrature_wheel_speed
  import qws_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [REQ_W-1:0]        req_type,
  input  logic                    level_a,
  input  logic                    level_b,
  input  logic [MS_W-1:0]         interval_ms,
  input  logic                    cfg_write,
  input  logic [CPR_W-1:0]        cfg_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] rpm_q8,
  output logic signed [OUT_W-1:0] count_change,
  output logic                    clipped,
  output logic                    bad_interval
);

  cmd_t    cmd;
  status_t status;

  qws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  qws_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .level_a      (level_a),
    .level_b      (level_b),
    .interval_ms  (interval_ms),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .status       (status),
    .rpm_q8       (rpm_q8),
    .count_change (count_change),
    .clipped      (clipped),
    .bad_interval (bad_interval)
  );

endmodule
